// ===== hw/rtl/swtm_pkg.sv =====
// package for the sliding window trimmed mean unit
// shared widths, parameter defaults and the controller to datapath command word
package swtm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    localparam int WINDOW_LENGTH_DEF = 13;
    localparam int TRIM_COUNT_DEF    = 5;

    typedef struct packed {
        logic capture;
        logic remove;
        logic insert;
        logic rotate;
        logic acc_clear;
        logic acc_en;
        logic divide;
        logic load_out;
    } swtm_cmd_t;

endpackage

// ===== hw/rtl/sliding_window_trimmed_mean_unit.sv =====
// top level of the sliding window trimmed mean unit
// depends on swtm_pkg, swtm_ctrl, swtm_dp (and swtm_ram through swtm_dp)
//
// channel   dir   word
// s_axis    in    tdata[11:0] sample, upper bits zero
// m_axis    out   tdata[11:0] baseline, upper bits zero
//
// a new word is accepted only after the previous result has been loaded for output
// each word passes remove, insert, the rotating walk over the sorted row and divide
// reset loads the sorted row with 0..length-1; the window ram needs no clearing pass
// a result waits in the output register; the next word is accepted meanwhile
// a held result stalls the following word only at its final load
module sliding_window_trimmed_mean_unit #(
    parameter int WINDOW_LENGTH = swtm_pkg::WINDOW_LENGTH_DEF,
    parameter int TRIM_COUNT    = swtm_pkg::TRIM_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [swtm_pkg::TDATA_W-1:0] s_axis_tdata,   // sample
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [swtm_pkg::TDATA_W-1:0] m_axis_tdata    // baseline
);
    import swtm_pkg::*;

    localparam int TRIM_EFF = (2 * TRIM_COUNT >= WINDOW_LENGTH) ?
                              (WINDOW_LENGTH - 1) / 2 : TRIM_COUNT;
    localparam int COUNT_N  = WINDOW_LENGTH - 2 * TRIM_EFF;

    swtm_cmd_t           cmd;
    logic [SAMPLE_W-1:0] baseline;

    swtm_ctrl #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .TRIM          (TRIM_EFF),
        .COUNT_N       (COUNT_N)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    swtm_dp #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .COUNT_N       (COUNT_N)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sample   (s_axis_tdata[SAMPLE_W-1:0]),
        .baseline (baseline)
    );

    assign m_axis_tdata = {{(TDATA_W-SAMPLE_W){1'b0}}, baseline};

endmodule

// ===== hw/rtl/swtm_ram.sv =====
// generic single port ram with registered read
// no dependencies
module swtm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 13
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/swtm_dp.sv =====
// datapath: window ram, sorted row of cells, accumulator and reciprocal divider
// depends on swtm_pkg and swtm_ram
module swtm_dp #(
    parameter int WINDOW_LENGTH = swtm_pkg::WINDOW_LENGTH_DEF,
    parameter int COUNT_N       = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swtm_pkg::swtm_cmd_t           cmd,
    input  logic [swtm_pkg::SAMPLE_W-1:0] sample,
    output logic [swtm_pkg::SAMPLE_W-1:0] baseline
);
    import swtm_pkg::*;

    localparam int SLOT_W  = $clog2(WINDOW_LENGTH);
    localparam int CNT_W   = $clog2(COUNT_N + 1);
    localparam int SUM_W   = SAMPLE_W + CNT_W;
    localparam int SHIFT   = SUM_W + $clog2(COUNT_N);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(COUNT_N) - 64'd1) / 64'(COUNT_N));
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);

    logic [SAMPLE_W-1:0] row_reg [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] rem_row [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] ins_row [WINDOW_LENGTH];
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] rd_data;
    logic [SAMPLE_W-1:0] old_value;
    logic [SLOT_W-1:0]   slot_reg;
    logic                first_lap_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] quo_reg;
    logic [SAMPLE_W-1:0] baseline_reg;
    logic                row_sorted;

    swtm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .clk     (clk),
        .wr_en   (cmd.remove),
        .addr    (slot_reg),
        .wr_data (sample_reg),
        .rd_data (rd_data)
    );

    // in the first lap, slots not yet written count as holding their reset value, the slot index
    assign old_value = first_lap_reg ? {{(SAMPLE_W-SLOT_W){1'b0}}, slot_reg} : rd_data;

    // drop the first entry equal to the old value, close the gap
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < WINDOW_LENGTH; i++)
        begin
            seen = seen | (row_reg[i] == old_value);
            if (seen && (i < WINDOW_LENGTH - 1))
            begin
                rem_row[i] = row_reg[(i < WINDOW_LENGTH - 1) ? i + 1 : i];
            end
            else
            begin
                rem_row[i] = row_reg[i];
            end
        end
    end

    // insert after all entries <= new sample among the first length-1 cells
    always_comb
    begin
        logic run;
        logic prev;
        run  = 1'b1;
        prev = 1'b1;
        for (int i = 0; i < WINDOW_LENGTH; i++)
        begin
            prev = run;
            if (i < WINDOW_LENGTH - 1)
            begin
                run = run & (row_reg[i] <= sample_reg);
            end
            else
            begin
                run = 1'b0;
            end
            if (run)
            begin
                ins_row[i] = row_reg[i];
            end
            else if (prev)
            begin
                ins_row[i] = sample_reg;
            end
            else
            begin
                ins_row[i] = row_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                row_reg[i] <= SAMPLE_W'(i);
            end
            slot_reg      <= '0;
            first_lap_reg <= 1'b1;
        end
        else
        begin
            if (cmd.remove)
            begin
                row_reg <= rem_row;
                if (slot_reg == SLOT_LAST)
                begin
                    slot_reg      <= '0;
                    first_lap_reg <= 1'b0;
                end
                else
                begin
                    slot_reg <= slot_reg + SLOT_W'(1);
                end
            end
            else if (cmd.insert)
            begin
                row_reg <= ins_row;
            end
            else if (cmd.rotate)
            begin
                for (int i = 0; i < WINDOW_LENGTH; i++)
                begin
                    row_reg[i] <= row_reg[(i + 1) % WINDOW_LENGTH];
                end
            end
        end
    end

    // floor of sum / count by multiplying with a rounded-up reciprocal
    assign product = PROD_W'(acc_reg) * PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + {{CNT_W{1'b0}}, row_reg[0]};
        end
        if (cmd.divide)
        begin
            quo_reg <= product[SHIFT +: SAMPLE_W];
        end
        if (cmd.load_out)
        begin
            baseline_reg <= quo_reg;
        end
    end

    assign baseline = baseline_reg;

    always_comb
    begin
        row_sorted = 1'b1;
        for (int i = 0; i < WINDOW_LENGTH - 1; i++)
        begin
            row_sorted = row_sorted & (row_reg[i] <= row_reg[i + 1]);
        end
    end

`ifndef NO_ASSERTIONS
    a_sorted_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> row_sorted)
        else $error("sorted row out of order after insert");

    a_first_lap_ends_at_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_lap_reg) |-> (slot_reg == '0))
        else $error("first lap ended away from slot zero");
`endif

endmodule

// ===== hw/rtl/swtm_ctrl.sv =====
// controller: sequences capture, remove, insert, summing walk, divide and output load
// depends on swtm_pkg
module swtm_ctrl #(
    parameter int WINDOW_LENGTH = swtm_pkg::WINDOW_LENGTH_DEF,
    parameter int TRIM          = swtm_pkg::TRIM_COUNT_DEF,
    parameter int COUNT_N       = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output swtm_pkg::swtm_cmd_t cmd
);
    import swtm_pkg::*;

    localparam int STEP_W   = $clog2(WINDOW_LENGTH + 1);
    localparam logic [STEP_W-1:0] SUM_LAST = STEP_W'(WINDOW_LENGTH - 1);
    localparam logic [STEP_W-1:0] MID_LO   = STEP_W'(TRIM);
    localparam logic [STEP_W-1:0] MID_HI   = STEP_W'(TRIM + COUNT_N);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REMOVE,
        S_INSERT,
        S_SUM,
        S_DIV,
        S_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_ready && in_valid;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                cmd.insert    = 1'b1;
                cmd.acc_clear = 1'b1;
                step_next     = '0;
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                cmd.rotate = 1'b1;
                cmd.acc_en = (step_reg >= MID_LO) && (step_reg < MID_HI);
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == SUM_LAST)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.divide = 1'b1;
                step_next  = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a word not yet taken");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_REMOVE))
        else $error("accepted word did not start processing");

    a_walk_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INSERT) |=> (state_reg == S_SUM && step_reg == '0))
        else $error("summing walk did not start at cell zero");
`endif

endmodule
